@@ rtl/tpst_pkg.sv @@
// shared types, codes and helpers for the three-phase swing trajectory block
// no dependencies; used by every file in rtl/
package tpst_pkg;

  localparam int PosW  = 32;
  localparam int TickW = 16;
  localparam int DvdW  = 34;
  localparam int DsrW  = 32;

  // configuration register indexes
  localparam logic [1:0] CFG_SPEED    = 2'd0;
  localparam logic [1:0] CFG_LIFT     = 2'd1;
  localparam logic [1:0] CFG_MIN_TICK = 2'd2;
  localparam logic [1:0] CFG_MAX_TICK = 2'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LIFT    = 2'd1,
    PH_ADVANCE = 2'd2,
    PH_LOWER   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_DIST,
    ST_DIVN,
    ST_DIVN_WAIT,
    ST_CLAMP,
    ST_DIVV,
    ST_DIVV_WAIT,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                   op;
    logic signed [PosW-1:0] start_x;
    logic signed [PosW-1:0] start_y;
    logic signed [PosW-1:0] start_z;
    logic signed [PosW-1:0] goal_x;
    logic signed [PosW-1:0] goal_y;
    logic signed [PosW-1:0] goal_z;
  } in_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic                   finished;
    logic [1:0]             phase;
  } out_t;

  // saturate a wide signed value to the position range
  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh7FFFFFFF;
    lo = -hi - 50'sd1;
    if (v > hi) begin
      sat_pos = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat_pos = 32'sh80000000;
    end else begin
      sat_pos = v[PosW-1:0];
    end
  endfunction

endpackage

@@ rtl/tpst_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on tpst_pkg for operand widths
module tpst_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tpst_pkg::DvdW-1:0]      dividend,
  input  logic [tpst_pkg::DsrW-1:0]      divisor,
  output logic                           done,
  output logic [tpst_pkg::DvdW-1:0]      quotient
);

  logic [tpst_pkg::DsrW-1:0] rem;
  logic [tpst_pkg::DsrW-1:0] dsr;
  logic [5:0]                cnt;
  logic                      busy;
  logic [tpst_pkg::DsrW:0]   trial;
  logic                      ge;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quotient[tpst_pkg::DvdW-1]};
    ge    = trial >= {1'b0, dsr};
  end

  // control: busy flag, step count, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(tpst_pkg::DvdW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? tpst_pkg::DsrW'(trial - {1'b0, dsr}) : trial[tpst_pkg::DsrW-1:0];
      quotient <= {quotient[tpst_pkg::DvdW-2:0], ge};
    end
  end

endmodule

@@ rtl/three_phase_swing_trajectory.sv @@
// top level of the three-phase swing trajectory generator: sequencer and datapath
// depends on tpst_pkg and tpst_div
//
//   channel  | signals                          | transaction
//   ---------+----------------------------------+----------------------------
//   input    | in_valid, in_stall, in_data      | start or tick item
//   output   | out_valid, out_stall, out_data   | position, finished, phase
//   config   | cfg_wr_en, cfg_index, cfg_data   | register write, no reply
//
// idle tick: straight to the output; normal tick: one multiply then add per axis
// start or segment change: paced by the shared divider, which runs for the tick
// count and for each of the three axis velocities
// reset is synchronous and returns the swing to idle with zeroed points
// input stalls while an item is in work, also while its result waits behind a held output
module three_phase_swing_trajectory (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tpst_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tpst_pkg::out_t     out_data,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  tpst_pkg::state_t state, state_next;
  tpst_pkg::phase_t phase;

  logic [31:0] speed;
  logic [30:0] lift;
  logic [15:0] min_t;
  logic [15:0] max_t;

  logic [tpst_pkg::TickW-1:0] elapsed;
  logic [tpst_pkg::TickW-1:0] seg_ticks;
  logic signed [31:0] origin   [3];
  logic signed [31:0] seg_end  [3];
  logic signed [32:0] vel      [3];
  logic signed [31:0] touch    [3];
  logic signed [31:0] res_pos  [3];
  logic               res_fin;
  logic [1:0]         ax;
  logic [33:0]        manhattan;
  logic signed [49:0] prod;

  logic               in_acc;
  logic               div_start;
  logic               div_done;
  logic [33:0]        div_dvd;
  logic [31:0]        div_dsr;
  logic [33:0]        div_quo;
  logic signed [32:0] dlt;
  logic [31:0]        mag;
  logic [33:0]        n_lo;
  logic [15:0]        n_clamp;
  logic [31:0]        speed_eff;
  logic [32:0]        q_vel;
  logic               out_load;

  assign in_acc = in_valid && !in_stall;

  // per-axis delta and magnitude for the current axis
  always_comb begin
    dlt       = {seg_end[ax][31], seg_end[ax]} - {origin[ax][31], origin[ax]};
    mag       = dlt[32] ? 32'(-dlt) : dlt[31:0];
    speed_eff = (speed == 32'd0) ? 32'd1 : speed;
    q_vel     = div_quo[32:0];
    n_lo      = (div_quo < {18'd0, min_t}) ? {18'd0, min_t} : div_quo;
    n_clamp   = (n_lo > {18'd0, max_t}) ? max_t : n_lo[15:0];
  end

  // divider operands: distance over speed, or axis delta over tick count
  always_comb begin
    if (state == tpst_pkg::ST_DIVN) begin
      div_dvd = manhattan;
      div_dsr = speed_eff;
    end else begin
      div_dvd = {2'd0, mag};
      div_dsr = {16'd0, seg_ticks};
    end
  end

  tpst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tpst_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.op == tpst_pkg::OP_START) begin
            state_next = tpst_pkg::ST_DIST;
          end else if (phase == tpst_pkg::PH_IDLE) begin
            state_next = tpst_pkg::ST_OUT;
          end else begin
            state_next = tpst_pkg::ST_TICK;
          end
        end
      end
      tpst_pkg::ST_TICK: begin
        if (elapsed >= seg_ticks) begin
          state_next = (phase == tpst_pkg::PH_LOWER) ? tpst_pkg::ST_OUT : tpst_pkg::ST_DIST;
        end else begin
          state_next = tpst_pkg::ST_MUL;
        end
      end
      tpst_pkg::ST_DIST: begin
        if (ax == 2'd2) state_next = tpst_pkg::ST_DIVN;
      end
      tpst_pkg::ST_DIVN:      state_next = tpst_pkg::ST_DIVN_WAIT;
      tpst_pkg::ST_DIVN_WAIT: begin
        if (div_done) state_next = tpst_pkg::ST_CLAMP;
      end
      tpst_pkg::ST_CLAMP:     state_next = tpst_pkg::ST_DIVV;
      tpst_pkg::ST_DIVV: begin
        if (seg_ticks != '0) begin
          state_next = tpst_pkg::ST_DIVV_WAIT;
        end else if (ax == 2'd2) begin
          state_next = tpst_pkg::ST_OUT;
        end
      end
      tpst_pkg::ST_DIVV_WAIT: begin
        if (div_done) state_next = (ax == 2'd2) ? tpst_pkg::ST_OUT : tpst_pkg::ST_DIVV;
      end
      tpst_pkg::ST_MUL:       state_next = tpst_pkg::ST_SUM;
      tpst_pkg::ST_SUM: begin
        state_next = (ax == 2'd2) ? tpst_pkg::ST_OUT : tpst_pkg::ST_MUL;
      end
      tpst_pkg::ST_OUT: begin
        if (out_load) state_next = tpst_pkg::ST_IDLE;
      end
      default: state_next = tpst_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state != tpst_pkg::ST_IDLE);
    div_start = (state == tpst_pkg::ST_DIVN) ||
                ((state == tpst_pkg::ST_DIVV) && (seg_ticks != '0));
    out_load  = (state == tpst_pkg::ST_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= 32'd6554;
      lift  <= 31'd3277;
      min_t <= 16'd150;
      max_t <= 16'd2000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tpst_pkg::CFG_SPEED:    speed <= cfg_data;
        tpst_pkg::CFG_LIFT:     lift  <= cfg_data[30:0];
        tpst_pkg::CFG_MIN_TICK: min_t <= cfg_data[15:0];
        tpst_pkg::CFG_MAX_TICK: max_t <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // swing state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tpst_pkg::PH_IDLE;
      elapsed   <= '0;
      seg_ticks <= '0;
      ax        <= '0;
      for (int i = 0; i < 3; i++) begin
        origin[i]  <= '0;
        seg_end[i] <= '0;
        vel[i]     <= '0;
        touch[i]   <= '0;
      end
    end else begin
      unique case (state)
        tpst_pkg::ST_IDLE: begin
          ax        <= '0;
          manhattan <= '0;
          if (in_acc) begin
            res_fin <= (in_data.op == tpst_pkg::OP_TICK) && (phase == tpst_pkg::PH_IDLE);
            if (in_data.op == tpst_pkg::OP_START) begin
              origin[0]  <= in_data.start_x;
              origin[1]  <= in_data.start_y;
              origin[2]  <= in_data.start_z;
              seg_end[0] <= in_data.start_x;
              seg_end[1] <= in_data.start_y;
              seg_end[2] <= tpst_pkg::sat_pos(50'(in_data.start_z) + 50'($signed({1'b0, lift})));
              touch[0]   <= in_data.goal_x;
              touch[1]   <= in_data.goal_y;
              touch[2]   <= in_data.goal_z;
              res_pos[0] <= in_data.start_x;
              res_pos[1] <= in_data.start_y;
              res_pos[2] <= in_data.start_z;
              phase      <= tpst_pkg::PH_LIFT;
            end else if (phase == tpst_pkg::PH_IDLE) begin
              for (int i = 0; i < 3; i++) res_pos[i] <= touch[i];
            end else if (elapsed != '1) begin
              elapsed <= elapsed + 1'b1;
            end
          end
        end
        tpst_pkg::ST_TICK: begin
          // segment completion plans the next one or ends the swing
          if (elapsed >= seg_ticks) begin
            for (int i = 0; i < 3; i++) begin
              res_pos[i] <= seg_end[i];
              origin[i]  <= seg_end[i];
            end
            seg_end[0] <= touch[0];
            seg_end[1] <= touch[1];
            // advance segment keeps the foot lifted over the touchdown point
            seg_end[2] <= (phase == tpst_pkg::PH_LIFT) ?
                          tpst_pkg::sat_pos(50'(touch[2]) + 50'($signed({1'b0, lift}))) :
                          touch[2];
            if (phase == tpst_pkg::PH_LIFT) begin
              phase <= tpst_pkg::PH_ADVANCE;
            end else if (phase == tpst_pkg::PH_ADVANCE) begin
              phase <= tpst_pkg::PH_LOWER;
            end else begin
              phase   <= tpst_pkg::PH_IDLE;
              res_fin <= 1'b1;
            end
          end
        end
        tpst_pkg::ST_DIST: begin
          manhattan <= manhattan + {2'd0, mag};
          ax        <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        tpst_pkg::ST_CLAMP: begin
          seg_ticks <= n_clamp;
          elapsed   <= '0;
        end
        tpst_pkg::ST_DIVV: begin
          if (seg_ticks == '0) begin
            vel[ax] <= '0;
            ax      <= ax + 2'd1;
          end
        end
        tpst_pkg::ST_DIVV_WAIT: begin
          if (div_done) begin
            vel[ax] <= dlt[32] ? -$signed(q_vel) : $signed(q_vel);
            ax      <= ax + 2'd1;
          end
        end
        tpst_pkg::ST_MUL: begin
          prod <= vel[ax] * $signed({1'b0, elapsed});
        end
        tpst_pkg::ST_SUM: begin
          res_pos[ax] <= tpst_pkg::sat_pos(50'(origin[ax]) + prod);
          ax          <= ax + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.pos_x    <= res_pos[0];
      out_data.pos_y    <= res_pos[1];
      out_data.pos_z    <= res_pos[2];
      out_data.finished <= res_fin;
      out_data.phase    <= phase;
    end
  end

endmodule
